// File: sv/bhr_pkg.sv
// Shared types and constants for the button hold and auto-repeat event queue.
package bhr_pkg;

	localparam int ButtonCount = 8;
	localparam int ButtonW = 3;
	localparam int LevelW = 6;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [1:0] OpPress = 2'd0;
	localparam logic [1:0] OpRelease = 2'd1;
	localparam logic [1:0] OpPoll = 2'd2;

	localparam logic [CfgIdxW-1:0] CfgHoldTime = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgRepeatDelay = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgRepeatPeriod = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgHoldMask = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgRepeatMask = 3'd4;

	localparam logic KindShort = 1'b0;
	localparam logic KindHold = 1'b1;

	localparam logic [15:0] ResetHoldTime = 16'd500;
	localparam logic [15:0] ResetRepeatDelay = 16'd400;
	localparam logic [15:0] ResetRepeatPeriod = 16'd120;
	localparam logic [ButtonCount-1:0] ResetHoldMask = 8'hC0;
	localparam logic [ButtonCount-1:0] ResetRepeatMask = 8'h0F;

	typedef struct packed {
		logic [1:0]         operation;
		logic [ButtonW-1:0] button;
		logic [31:0]        now_ms;
	} in_item_t;

	typedef struct packed {
		logic                   event_valid;
		logic [ButtonW-1:0]     event_button;
		logic                   event_kind;
		logic [ButtonCount-1:0] down_mask;
		logic [LevelW-1:0]      queue_level;
	} out_item_t;

	typedef struct packed {
		logic               kind;
		logic [ButtonW-1:0] button;
	} ev_entry_t;

	typedef struct packed {
		logic      push;
		ev_entry_t push_entry;
		logic      rd;
		logic      pop;
	} ring_cmd_t;

	typedef struct packed {
		logic              empty;
		logic [LevelW-1:0] level;
		ev_entry_t         entry;
	} ring_stat_t;

	typedef struct packed {
		logic [31:0] press_time;
		logic [31:0] next_repeat;
	} btn_rec_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRESS,
		ST_RELEASE,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_WALK_REP,
		ST_POP_RD,
		ST_POP_DATA,
		ST_REPORT
	} state_t;

endpackage

// File: sv/button_hold_repeat_event_queue_top.sv
// Top level: button state sequencer with per-button timer memory and event ring.
//
// Channel  Direction  Handshake              Payload
// item     in         start high, busy low   in_item_t (operation, button, now_ms)
// result   out        done strobe, one cycle out_item_t (event and status fields)
// cfg      in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// Press and release pass through their own state and the report state before done rises;
// a no-op goes straight to the report state. A poll walks the eight buttons through the
// timer memory, a button that is up in the read state alone and one that is down through the
// read, check and repeat states, then pops (only when the queue holds an event) and reports.
// busy falls as done rises; cfg_ready is high only while idle with start low.
// Reset restores flags, ring pointers and configuration; memories are not cleared.
module button_hold_repeat_event_queue_top import bhr_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  in_item_t            item,
	output logic                done,
	output out_item_t           result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam logic [ButtonW-1:0] LastButton = ButtonW'(ButtonCount - 1);

	state_t                 state_q;
	state_t                 state_nxt;
	in_item_t               item_q;
	logic [ButtonW-1:0]     idx_q;
	logic [ButtonCount-1:0] down_q;
	logic [ButtonCount-1:0] hold_done_q;
	logic                   rep_fire_q;
	logic                   ev_valid_q;
	logic                   done_q;
	out_item_t              result_q;

	logic [15:0]            hold_time_q;
	logic [15:0]            repeat_delay_q;
	logic [15:0]            repeat_period_q;
	logic [ButtonCount-1:0] hold_mask_q;
	logic [ButtonCount-1:0] repeat_mask_q;

	btn_rec_t               btn_mem [ButtonCount];
	btn_rec_t               btn_rd_q;
	logic                   btn_rd;
	logic                   btn_wr;
	logic [ButtonW-1:0]     btn_addr;
	btn_rec_t               btn_wdata;

	ring_cmd_t              ring_cmd;
	ring_stat_t             ring_stat;

	logic                   accept;
	logic [31:0]            held;
	logic                   hold_fire;
	logic                   rep_fire;

	bhr_ring #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (ring_cmd),
		.stat  (ring_stat)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign done = done_q;
	assign result = result_q;

	assign held = item_q.now_ms - btn_rd_q.press_time;
	assign hold_fire = hold_mask_q[idx_q] && !hold_done_q[idx_q]
		&& (held >= {16'b0, hold_time_q});
	assign rep_fire = repeat_mask_q[idx_q] && (held >= {16'b0, repeat_delay_q})
		&& (item_q.now_ms >= btn_rd_q.next_repeat);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (item.operation)
						OpPress:   state_nxt = ST_PRESS;
						OpRelease: state_nxt = ST_RELEASE;
						OpPoll:    state_nxt = ST_WALK_RD;
						default:   state_nxt = ST_REPORT;
					endcase
				end
			end
			ST_PRESS:    state_nxt = ST_REPORT;
			ST_RELEASE:  state_nxt = ST_REPORT;
			ST_WALK_RD: begin
				if (down_q[idx_q]) begin
					state_nxt = ST_WALK_CHK;
				end else if (idx_q == LastButton) begin
					state_nxt = ST_POP_RD;
				end
			end
			ST_WALK_CHK: state_nxt = ST_WALK_REP;
			ST_WALK_REP: begin
				if (idx_q == LastButton) begin
					state_nxt = ST_POP_RD;
				end else begin
					state_nxt = ST_WALK_RD;
				end
			end
			ST_POP_RD: begin
				if (ring_stat.empty) begin
					state_nxt = ST_REPORT;
				end else begin
					state_nxt = ST_POP_DATA;
				end
			end
			ST_POP_DATA: state_nxt = ST_REPORT;
			ST_REPORT:   state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		btn_rd = 1'b0;
		btn_wr = 1'b0;
		btn_addr = idx_q;
		btn_wdata = btn_rd_q;
		ring_cmd = '0;
		case (state_q)
			ST_PRESS: begin
				btn_addr = item_q.button;
				btn_wdata.press_time = item_q.now_ms;
				btn_wdata.next_repeat = item_q.now_ms + 32'(repeat_delay_q);
				if (!down_q[item_q.button]) begin
					btn_wr = 1'b1;
					ring_cmd.push = !hold_mask_q[item_q.button];
				end
				ring_cmd.push_entry.kind = KindShort;
				ring_cmd.push_entry.button = item_q.button;
			end
			ST_RELEASE: begin
				ring_cmd.push = down_q[item_q.button] && hold_mask_q[item_q.button]
					&& !hold_done_q[item_q.button];
				ring_cmd.push_entry.kind = KindShort;
				ring_cmd.push_entry.button = item_q.button;
			end
			ST_WALK_RD: begin
				btn_rd = down_q[idx_q];
			end
			ST_WALK_CHK: begin
				ring_cmd.push = hold_fire;
				ring_cmd.push_entry.kind = KindHold;
				ring_cmd.push_entry.button = idx_q;
			end
			ST_WALK_REP: begin
				btn_wdata.next_repeat = item_q.now_ms + 32'(repeat_period_q);
				btn_wr = rep_fire_q;
				ring_cmd.push = rep_fire_q;
				ring_cmd.push_entry.kind = KindShort;
				ring_cmd.push_entry.button = idx_q;
			end
			ST_POP_RD: begin
				ring_cmd.rd = !ring_stat.empty;
			end
			ST_POP_DATA: begin
				ring_cmd.pop = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (btn_wr) begin
			btn_mem[btn_addr] <= btn_wdata;
		end
		if (btn_rd) begin
			btn_rd_q <= btn_mem[btn_addr];
		end
		if (accept) begin
			item_q <= item;
		end
		if (state_q == ST_WALK_CHK) begin
			rep_fire_q <= rep_fire;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			down_q <= '0;
			hold_done_q <= '0;
			ev_valid_q <= 1'b0;
			done_q <= 1'b0;
			result_q <= '0;
			hold_time_q <= ResetHoldTime;
			repeat_delay_q <= ResetRepeatDelay;
			repeat_period_q <= ResetRepeatPeriod;
			hold_mask_q <= ResetHoldMask;
			repeat_mask_q <= ResetRepeatMask;
		end else begin
			state_q <= state_nxt;
			done_q <= (state_q == ST_REPORT);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgHoldTime:     hold_time_q <= cfg_data;
					CfgRepeatDelay:  repeat_delay_q <= cfg_data;
					CfgRepeatPeriod: repeat_period_q <= cfg_data;
					CfgHoldMask:     hold_mask_q <= cfg_data[ButtonCount-1:0];
					CfgRepeatMask:   repeat_mask_q <= cfg_data[ButtonCount-1:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q <= '0;
						ev_valid_q <= 1'b0;
					end
				end
				ST_PRESS: begin
					if (!down_q[item_q.button]) begin
						down_q[item_q.button] <= 1'b1;
						hold_done_q[item_q.button] <= 1'b0;
					end
				end
				ST_RELEASE: begin
					down_q[item_q.button] <= 1'b0;
					hold_done_q[item_q.button] <= 1'b0;
				end
				ST_WALK_RD: begin
					if (!down_q[idx_q]) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_WALK_CHK: begin
					if (hold_fire) begin
						hold_done_q[idx_q] <= 1'b1;
					end
				end
				ST_WALK_REP: begin
					idx_q <= idx_q + 1'b1;
				end
				ST_POP_DATA: begin
					ev_valid_q <= 1'b1;
				end
				ST_REPORT: begin
					result_q.event_valid <= ev_valid_q;
					result_q.event_button <= ev_valid_q ? ring_stat.entry.button : '0;
					result_q.event_kind <= ev_valid_q ? ring_stat.entry.kind : 1'b0;
					result_q.down_mask <= down_q;
					result_q.queue_level <= ring_stat.level;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: sv/bhr_ring.sv
// Event ring: one-slot-empty circular queue in a synchronous memory.
module bhr_ring import bhr_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ring_cmd_t  cmd,
	output ring_stat_t stat
);

	localparam int PtrW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;

	ev_entry_t        mem [QUEUE_DEPTH];
	ev_entry_t        rd_q;
	logic [PtrW-1:0]  head_q;
	logic [PtrW-1:0]  tail_q;
	logic [PtrW-1:0]  head_nxt;
	logic [PtrW-1:0]  tail_nxt;
	logic             full;
	logic [PtrW:0]    lvl;
	logic [PtrW+6:0]  lvl_ext;

	assign head_nxt = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign full = (tail_nxt == head_q);

	always_comb begin
		if (tail_q >= head_q) begin
			lvl = {1'b0, tail_q} - {1'b0, head_q};
		end else begin
			lvl = {1'b0, tail_q} + (PtrW+1)'(QUEUE_DEPTH) - {1'b0, head_q};
		end
	end

	assign lvl_ext = {6'b0, lvl};

	always_ff @(posedge clk) begin
		if (cmd.push && !full) begin
			mem[tail_q] <= cmd.push_entry;
		end
		if (cmd.rd) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (cmd.push && !full) begin
				tail_q <= tail_nxt;
			end
			if (cmd.pop && (head_q != tail_q)) begin
				head_q <= head_nxt;
			end
		end
	end

	assign stat.empty = (head_q == tail_q);
	assign stat.level = lvl_ext[LevelW-1:0];
	assign stat.entry = rd_q;

endmodule
